// File: hw/rtl/agpd_pkg.sv
// Package for the altitude-gap PD release-time controller.
// Holds widths, register indexes, reset values and the configuration struct.
// Used by every module under hw/rtl; has no dependencies of its own.
package agpd_pkg;

   localparam int WINDOW    = 8;                   // gaps in the moving average, power of two
   localparam int WIN_LOG2  = $clog2(WINDOW);
   localparam int ALT_W     = 24;
   localparam int GAP_W     = ALT_W + 1;
   localparam int SUM_W     = GAP_W + WIN_LOG2;
   localparam int DELTA_W   = GAP_W + 1;
   localparam int CMP_W     = GAP_W + 1;
   localparam int LIM_W     = 16;
   localparam int GAIN_W    = 10;
   localparam int PPROD_W   = GAP_W + GAIN_W + 1;
   localparam int DPROD_W   = DELTA_W + GAIN_W + 1;
   localparam int REL_W     = DPROD_W + 1;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_OUTER_THRESHOLD  = 3'd0,
      REG_INNER_DEADBAND   = 3'd1,
      REG_MAX_RELEASE_TIME = 3'd2,
      REG_FAR_P_GAIN       = 3'd3,
      REG_FAR_D_GAIN       = 3'd4,
      REG_NEAR_D_GAIN      = 3'd5
   } csr_index_type;

   localparam logic [LIM_W-1:0]  RST_OUTER_THRESHOLD  = 16'd40;
   localparam logic [LIM_W-1:0]  RST_INNER_DEADBAND   = 16'd10;
   localparam logic [LIM_W-1:0]  RST_MAX_RELEASE_TIME = 16'd5000;
   localparam logic [GAIN_W-1:0] RST_FAR_P_GAIN       = 10'd27;
   localparam logic [GAIN_W-1:0] RST_FAR_D_GAIN       = 10'd170;
   localparam logic [GAIN_W-1:0] RST_NEAR_D_GAIN      = 10'd130;

   typedef struct packed {
      logic [LIM_W-1:0]  outer_threshold;
      logic [LIM_W-1:0]  inner_deadband;
      logic [LIM_W-1:0]  max_release_time;
      logic [GAIN_W-1:0] far_p_gain;
      logic [GAIN_W-1:0] far_d_gain;
      logic [GAIN_W-1:0] near_d_gain;
   } cfg_type;

endpackage

// File: hw/rtl/agpd_csr.sv
// Configuration register file of the altitude-gap PD controller.
// Depends on agpd_pkg for register indexes, widths and reset values.
module agpd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [agpd_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [agpd_pkg::CSR_DAT_W-1:0]  wr_data,
   output agpd_pkg::cfg_type               cfg
);

   agpd_pkg::cfg_type cfg_ff;
   agpd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (agpd_pkg::csr_index_type'(wr_index))
            agpd_pkg::REG_OUTER_THRESHOLD:  cfg_in.outer_threshold  = wr_data;
            agpd_pkg::REG_INNER_DEADBAND:   cfg_in.inner_deadband   = wr_data;
            agpd_pkg::REG_MAX_RELEASE_TIME: cfg_in.max_release_time = wr_data;
            agpd_pkg::REG_FAR_P_GAIN:   cfg_in.far_p_gain  = wr_data[agpd_pkg::GAIN_W-1:0];
            agpd_pkg::REG_FAR_D_GAIN:   cfg_in.far_d_gain  = wr_data[agpd_pkg::GAIN_W-1:0];
            agpd_pkg::REG_NEAR_D_GAIN:  cfg_in.near_d_gain = wr_data[agpd_pkg::GAIN_W-1:0];
            default: cfg_in = cfg_ff;   // Unmapped indexes are ignored.
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.outer_threshold  <= agpd_pkg::RST_OUTER_THRESHOLD;
         cfg_ff.inner_deadband   <= agpd_pkg::RST_INNER_DEADBAND;
         cfg_ff.max_release_time <= agpd_pkg::RST_MAX_RELEASE_TIME;
         cfg_ff.far_p_gain       <= agpd_pkg::RST_FAR_P_GAIN;
         cfg_ff.far_d_gain       <= agpd_pkg::RST_FAR_D_GAIN;
         cfg_ff.near_d_gain      <= agpd_pkg::RST_NEAR_D_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/agpd_window.sv
// Gap window with running sum, moving average and average delta.
// Depends on agpd_pkg for widths and the window length.
module agpd_window (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic signed [agpd_pkg::GAP_W-1:0]    gap,
   output logic signed [agpd_pkg::GAP_W-1:0]    gap_q,
   output logic signed [agpd_pkg::GAP_W-1:0]    avg_q,
   output logic signed [agpd_pkg::DELTA_W-1:0]  delta_q
);

   logic signed [agpd_pkg::GAP_W-1:0]   win_ff [agpd_pkg::WINDOW];
   logic signed [agpd_pkg::GAP_W-1:0]   win_in [agpd_pkg::WINDOW];
   logic signed [agpd_pkg::SUM_W-1:0]   sum_ff;
   logic signed [agpd_pkg::SUM_W-1:0]   sum_in;
   logic signed [agpd_pkg::GAP_W-1:0]   last_avg_ff;
   logic signed [agpd_pkg::SUM_W-1:0]   biased;
   logic signed [agpd_pkg::SUM_W-1:0]   avg_full;
   logic signed [agpd_pkg::GAP_W-1:0]   avg_in;
   logic signed [agpd_pkg::DELTA_W-1:0] delta_in;
   logic signed [agpd_pkg::GAP_W-1:0]   gap_ff;
   logic signed [agpd_pkg::GAP_W-1:0]   avg_ff;
   logic signed [agpd_pkg::DELTA_W-1:0] delta_ff;

   // The window shifts toward index 0; index 0 holds the oldest gap.
   always_comb begin
      for (int i = 0; i < agpd_pkg::WINDOW - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[agpd_pkg::WINDOW-1] = gap;
   end

   // Running sum: drop the oldest gap, add the newest.
   assign sum_in = sum_ff - agpd_pkg::SUM_W'(win_ff[0]) + agpd_pkg::SUM_W'(gap);

   // Divide by the window length, truncating toward zero.
   assign biased   = sum_in[agpd_pkg::SUM_W-1]
                   ? sum_in + agpd_pkg::SUM_W'(agpd_pkg::WINDOW - 1)
                   : sum_in;
   assign avg_full = biased >>> agpd_pkg::WIN_LOG2;
   assign avg_in   = $signed(avg_full[agpd_pkg::GAP_W-1:0]);
   assign delta_in = agpd_pkg::DELTA_W'(avg_in) - agpd_pkg::DELTA_W'(last_avg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < agpd_pkg::WINDOW; i++) begin
            win_ff[i] <= '0;
         end
         sum_ff      <= '0;
         last_avg_ff <= '0;
      end else if (load) begin
         win_ff      <= win_in;
         sum_ff      <= sum_in;
         last_avg_ff <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         gap_ff   <= gap;
         avg_ff   <= avg_in;
         delta_ff <= delta_in;
      end
   end

   assign gap_q   = gap_ff;
   assign avg_q   = avg_ff;
   assign delta_q = delta_ff;

endmodule

// File: hw/rtl/agpd_law.sv
// Control law: zone selection, P and D products, then sum and clamp.
// Depends on agpd_pkg for widths and the configuration struct.
module agpd_law (
   input  logic                                 clock,
   input  logic                                 load_mul,
   input  logic                                 load_out,
   input  agpd_pkg::cfg_type                    cfg,
   input  logic signed [agpd_pkg::GAP_W-1:0]    gap,
   input  logic signed [agpd_pkg::GAP_W-1:0]    avg,
   input  logic signed [agpd_pkg::DELTA_W-1:0]  delta,
   output logic [agpd_pkg::LIM_W-1:0]           release_ms
);

   localparam int PadW = agpd_pkg::CMP_W - agpd_pkg::LIM_W;

   logic signed [agpd_pkg::CMP_W-1:0]   inner_s;
   logic signed [agpd_pkg::CMP_W-1:0]   outer_s;
   logic signed [agpd_pkg::CMP_W-1:0]   gap_c;
   logic signed [agpd_pkg::CMP_W-1:0]   avg_c;
   logic                                in_band;
   logic                                far_zone;
   logic                                near_zone;
   logic [agpd_pkg::GAIN_W-1:0]         p_gain;
   logic [agpd_pkg::GAIN_W-1:0]         d_gain;
   logic signed [agpd_pkg::PPROD_W-1:0] p_prod_in;
   logic signed [agpd_pkg::DPROD_W-1:0] d_prod_in;
   logic signed [agpd_pkg::PPROD_W-1:0] p_prod_ff;
   logic signed [agpd_pkg::DPROD_W-1:0] d_prod_ff;
   logic signed [agpd_pkg::REL_W-1:0]   rel;
   logic signed [agpd_pkg::REL_W-1:0]   max_s;
   logic [agpd_pkg::LIM_W-1:0]          release_in;
   logic [agpd_pkg::LIM_W-1:0]          release_ff;

   assign inner_s = $signed({{PadW{1'b0}}, cfg.inner_deadband});
   assign outer_s = $signed({{PadW{1'b0}}, cfg.outer_threshold});
   assign gap_c   = agpd_pkg::CMP_W'(gap);
   assign avg_c   = agpd_pkg::CMP_W'(avg);

   assign in_band   = (gap_c < inner_s) && (gap_c > -inner_s)
                   && (avg_c < inner_s) && (avg_c > -inner_s);
   assign far_zone  = gap_c > outer_s;
   assign near_zone = gap_c > -outer_s;

   // A zero gain stands in for a term that does not apply in the zone.
   always_comb begin
      p_gain = '0;
      d_gain = '0;
      if (!in_band) begin
         if (far_zone) begin
            p_gain = cfg.far_p_gain;
            d_gain = cfg.far_d_gain;
         end else if (near_zone) begin
            d_gain = cfg.near_d_gain;
         end
      end
   end

   assign p_prod_in = agpd_pkg::PPROD_W'(gap) * agpd_pkg::PPROD_W'($signed({1'b0, p_gain}));
   assign d_prod_in = agpd_pkg::DPROD_W'(delta) * agpd_pkg::DPROD_W'($signed({1'b0, d_gain}));

   always_ff @(posedge clock) begin
      if (load_mul) begin
         p_prod_ff <= p_prod_in;
         d_prod_ff <= d_prod_in;
      end
   end

   assign rel   = agpd_pkg::REL_W'(p_prod_ff) + agpd_pkg::REL_W'(d_prod_ff);
   assign max_s = $signed({{(agpd_pkg::REL_W - agpd_pkg::LIM_W){1'b0}}, cfg.max_release_time});

   always_comb begin
      if (rel > max_s) begin
         release_in = cfg.max_release_time;
      end else if (rel < 0) begin
         release_in = '0;
      end else begin
         release_in = rel[agpd_pkg::LIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         release_ff <= release_in;
      end
   end

   assign release_ms = release_ff;

endmodule

// File: hw/rtl/altitude_gap_pd_release_time.sv
// Altitude-gap PD release-time controller, top level.
// An accepted transaction moves through stages 1 to 3 into the result register, stage 4,
// where rsp_valid shows it until it is taken with rsp_stall low.
// Throughput: one transaction per cycle unless rsp_stall holds the pipeline; the rate is set by
// the running-sum update of the gap window, which is formed combinationally for each sample.
// Reset (synchronous, active high) empties the pipeline, zeroes the gap window, running sum
// and previous average, and loads the default register values.
module altitude_gap_pd_release_time (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [agpd_pkg::ALT_W-1:0]    req_own_altitude,
   input  logic signed [agpd_pkg::ALT_W-1:0]    req_peer_altitude,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [agpd_pkg::LIM_W-1:0]           rsp_release_ms,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [agpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [agpd_pkg::CSR_DAT_W-1:0]       csr_data
);

   // The pipeline has four registered stages:
   //   stage 1 holds the gap, peer minus own, formed as the transaction arrives;
   //   stage 2 holds the gap, the new average and the delta against the previous average,
   //           and the window state advances exactly when a gap moves into this stage;
   //   stage 3 holds the P and D products, with the zone folded into the gains;
   //   stage 4 is the result register, holding the clamped release time.
   // Every stage can take a new transaction when it is empty or when the stage after it
   // takes its contents, so a finished result waiting on rsp_stall does not block the
   // stages behind it until they are all full.

   agpd_pkg::cfg_type cfg;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;
   logic load1, load2, load3, load4;

   logic signed [agpd_pkg::GAP_W-1:0]   gap_in;
   logic signed [agpd_pkg::GAP_W-1:0]   gap_ff;
   logic signed [agpd_pkg::GAP_W-1:0]   gap_s2;
   logic signed [agpd_pkg::GAP_W-1:0]   avg_s2;
   logic signed [agpd_pkg::DELTA_W-1:0] delta_s2;

   // Ready chain from the output back to the input.
   assign rdy4 = !v4_ff || !rsp_stall;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign load1 = rdy1 && req_valid;
   assign load2 = rdy2 && v1_ff;
   assign load3 = rdy3 && v2_ff;
   assign load4 = rdy4 && v3_ff;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff     : v2_ff;
   assign v3_in = rdy3 ? v2_ff     : v3_ff;
   assign v4_in = rdy4 ? v3_ff     : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Stage 1: the gap fits in one more bit than the altitudes, so it never wraps.
   assign gap_in = agpd_pkg::GAP_W'(req_peer_altitude) - agpd_pkg::GAP_W'(req_own_altitude);

   always_ff @(posedge clock) begin
      if (load1) begin
         gap_ff <= gap_in;
      end
   end

   assign req_stall = !rdy1;
   assign rsp_valid = v4_ff;

   // Registers are always ready; writes are expected only while the pipeline is idle.
   assign csr_ready = 1'b1;

   agpd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   agpd_window u_window (
      .clock   (clock),
      .reset   (reset),
      .load    (load2),
      .gap     (gap_ff),
      .gap_q   (gap_s2),
      .avg_q   (avg_s2),
      .delta_q (delta_s2)
   );

   agpd_law u_law (
      .clock      (clock),
      .load_mul   (load3),
      .load_out   (load4),
      .cfg        (cfg),
      .gap        (gap_s2),
      .avg        (avg_s2),
      .delta      (delta_s2),
      .release_ms (rsp_release_ms)
   );

   // The input is held off only when every stage is full and the result is not taken.
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && rsp_stall))
      else $error("input held off while the pipeline has room");

   // An accepted transaction always lands in the first stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted transaction not captured in stage 1");

   // A delivered result with nothing behind it leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !v3_ff) |=> !rsp_valid)
      else $error("result repeated after delivery");

endmodule

// File: dv/release_time_checker.sv
// Checker for the altitude-gap PD release-time controller.
// Watches the sample, result and register channels, predicts each release time and
// compares it. Depends on agpd_pkg for widths, register indexes and reset values.
module release_time_checker
   import agpd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [ALT_W-1:0]  req_own_altitude,
   input  logic signed [ALT_W-1:0]  req_peer_altitude,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [LIM_W-1:0]         rsp_release_ms,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DAT_W-1:0]     csr_data,
   output int                       fail_count,
   output int                       pending_count,
   output int                       checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type           settings;
   longint            gap_history [WINDOW];
   longint            prev_average;
   logic [LIM_W-1:0]  release_queue [$];
   int                errors  = 0;
   int                checked = 0;

   // Shifts the new gap into the window and works out the clamped release time.
   function automatic logic [LIM_W-1:0] predict_release(input logic signed [ALT_W-1:0] own,
                                                        input logic signed [ALT_W-1:0] peer);
      longint gap;
      longint sum;
      longint average;
      longint delta;
      longint release_raw;
      longint inner;
      longint outer;
      int     i;
      gap = longint'(peer) - longint'(own);
      sum = 0;
      for (i = 0; i < WINDOW - 1; i++) begin
         gap_history[i] = gap_history[i + 1];
      end
      gap_history[WINDOW - 1] = gap;
      for (i = 0; i < WINDOW; i++) begin
         sum += gap_history[i];
      end
      // Signed division truncates toward zero, as the block's average does.
      average      = sum / WINDOW;
      delta        = average - prev_average;
      prev_average = average;
      inner = longint'(settings.inner_deadband);
      outer = longint'(settings.outer_threshold);
      if (gap < inner && gap > -inner && average < inner && average > -inner) begin
         release_raw = 0;
      end else if (gap > outer) begin
         release_raw = gap * longint'(settings.far_p_gain)
                     + delta * longint'(settings.far_d_gain);
      end else if (gap > -outer) begin
         release_raw = delta * longint'(settings.near_d_gain);
      end else begin
         release_raw = 0;
      end
      if (release_raw > longint'(settings.max_release_time)) begin
         release_raw = longint'(settings.max_release_time);
      end else if (release_raw < 0) begin
         release_raw = 0;
      end
      return release_raw[LIM_W-1:0];
   endfunction

   always @(posedge clock) begin
      logic [LIM_W-1:0] expected;
      if (reset) begin
         settings.outer_threshold  = RST_OUTER_THRESHOLD;
         settings.inner_deadband   = RST_INNER_DEADBAND;
         settings.max_release_time = RST_MAX_RELEASE_TIME;
         settings.far_p_gain       = RST_FAR_P_GAIN;
         settings.far_d_gain       = RST_FAR_D_GAIN;
         settings.near_d_gain      = RST_NEAR_D_GAIN;
         foreach (gap_history[i]) gap_history[i] = 0;
         prev_average = 0;
         release_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_OUTER_THRESHOLD:  settings.outer_threshold  = csr_data[LIM_W-1:0];
               REG_INNER_DEADBAND:   settings.inner_deadband   = csr_data[LIM_W-1:0];
               REG_MAX_RELEASE_TIME: settings.max_release_time = csr_data[LIM_W-1:0];
               REG_FAR_P_GAIN:       settings.far_p_gain       = csr_data[GAIN_W-1:0];
               REG_FAR_D_GAIN:       settings.far_d_gain       = csr_data[GAIN_W-1:0];
               REG_NEAR_D_GAIN:      settings.near_d_gain      = csr_data[GAIN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (release_queue.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: unexpected release time %0d with nothing pending",
                           $realtime, rsp_release_ms);
               end
            end else begin
               expected = release_queue.pop_front();
               checked++;
               if (rsp_release_ms !== expected) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: release_ms mismatch, expected %0d, got %0d",
                              $realtime, expected, rsp_release_ms);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            release_queue.push_back(predict_release(req_own_altitude, req_peer_altitude));
         end
      end
      fail_count    <= errors;
      checked_count <= checked;
      pending_count <= release_queue.size();
   end

endmodule

// File: dv/tb_top.sv
// Top of the release-time controller testbench: clock, reset, stimulus and verdict.
// Instantiates the controller and release_time_checker side by side.
// Depends on agpd_pkg and on both of those modules.
module tb_top;
   import agpd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The register port decodes three index bits but only six registers exist. These two
   // indexes must be ignored by the block.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam logic signed [ALT_W-1:0] ALT_MAX = {1'b0, {(ALT_W-1){1'b1}}};
   localparam logic signed [ALT_W-1:0] ALT_MIN = {1'b1, {(ALT_W-1){1'b0}}};

   localparam int RANDOM_PER_SETTING = 100;
   localparam int SETTING_COUNT      = 6;
   localparam int HOLD_OFF_CYCLES    = 300;

   logic                     clock;
   logic                     reset              = 1'b1;
   logic                     req_valid          = 1'b0;
   logic                     req_stall;
   logic signed [ALT_W-1:0]  req_own_altitude   = '0;
   logic signed [ALT_W-1:0]  req_peer_altitude  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall          = 1'b0;
   logic [LIM_W-1:0]         rsp_release_ms;
   logic                     csr_valid          = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index          = '0;
   logic [CSR_DAT_W-1:0]     csr_data           = '0;

   int     fail_count;
   int     pending_count;
   int     checked_count;
   int     send_idle_pct = 31;
   int     recv_idle_pct = 53;
   logic   hold_results  = 1'b0;
   int     samples_sent  = 0;

   // State of the gap trajectory that most random samples follow. It drifts slowly so
   // that the moving average settles, then now and then jumps to a new zone and scale.
   longint walk_gap   = 0;
   longint walk_scale = 20;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   altitude_gap_pd_release_time u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_own_altitude  (req_own_altitude),
      .req_peer_altitude (req_peer_altitude),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_release_ms    (rsp_release_ms),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   release_time_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_own_altitude  (req_own_altitude),
      .req_peer_altitude (req_peer_altitude),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_release_ms    (rsp_release_ms),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count)
   );

   // The result side stalls at random according to the current idle rate, and stalls
   // without a break while a hold-off is running.
   always @(posedge clock) begin
      rsp_stall <= hold_results || ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Offers one sample transaction and returns at the edge that accepts it. Valid is left
   // high so the next transaction can follow back to back; callers lower it when done.
   task automatic offer_sample(input logic signed [ALT_W-1:0] own,
                               input logic signed [ALT_W-1:0] peer);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_own_altitude  <= own;
      req_peer_altitude <= peer;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   // Waits until the checker has seen every predicted result, then lets the pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   function automatic longint signed_spread(input longint span);
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic signed [ALT_W-1:0] extreme_altitude();
      case ($urandom_range(0, 3))
         0:       return ALT_MAX;
         1:       return ALT_MIN;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // Builds one random sample transaction. Most follow the gap trajectory with a random
   // own altitude; the rest are fully random pairs or corner values of the altitude range.
   task automatic random_sample(output logic signed [ALT_W-1:0] own,
                                output logic signed [ALT_W-1:0] peer);
      logic [31:0] raw;
      longint      own_wide;
      longint      peer_wide;
      int          pick;
      pick     = $urandom_range(0, 99);
      raw      = $urandom;
      own_wide = longint'($signed(raw[ALT_W-1:0]));
      if (pick < 75) begin
         if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 3))
               0:       walk_scale = 20;
               1:       walk_scale = 120;
               2:       walk_scale = 3000;
               default: walk_scale = 200000;
            endcase
            walk_gap = signed_spread(walk_scale);
         end
         walk_gap  = walk_gap + signed_spread(walk_scale / 8 + 1);
         peer_wide = own_wide + walk_gap;
         if (peer_wide > longint'(ALT_MAX)) peer_wide = longint'(ALT_MAX);
         if (peer_wide < longint'(ALT_MIN)) peer_wide = longint'(ALT_MIN);
         own  = own_wide[ALT_W-1:0];
         peer = peer_wide[ALT_W-1:0];
      end else if (pick < 90) begin
         raw  = $urandom;
         own  = own_wide[ALT_W-1:0];
         peer = raw[ALT_W-1:0];
      end else begin
         own  = extreme_altitude();
         peer = extreme_altitude();
      end
   endtask

   // Loads one register setting while the block is idle. Settings 1 and 2 are the
   // extremes: everything zero, then everything all ones, which also shows that the gain
   // registers keep only their low bits. Both unused indexes get junk each time.
   task automatic apply_setting(input int which);
      logic [CSR_DAT_W-1:0] values [6];
      int                   i;
      for (i = 0; i < 6; i++) begin
         values[i] = CSR_DAT_W'($urandom_range(0, 16'hFFFF));
      end
      case (which)
         1: begin
            for (i = 0; i < 6; i++) values[i] = '0;
         end
         2: begin
            for (i = 0; i < 6; i++) values[i] = '1;
         end
         3: begin
            values[REG_OUTER_THRESHOLD]  = CSR_DAT_W'($urandom_range(0, 200));
            values[REG_INNER_DEADBAND]   = CSR_DAT_W'($urandom_range(0, 50));
            values[REG_MAX_RELEASE_TIME] = '1;
         end
         5: begin
            values[REG_OUTER_THRESHOLD]  = '0;
            values[REG_INNER_DEADBAND]   = '0;
            values[REG_MAX_RELEASE_TIME] = '1;
            values[REG_FAR_P_GAIN]       = 16'd1023;
            values[REG_FAR_D_GAIN]       = 16'd1023;
            values[REG_NEAR_D_GAIN]      = 16'd1023;
         end
         default: begin
            values[REG_OUTER_THRESHOLD] = CSR_DAT_W'($urandom_range(0, 3000));
            values[REG_INNER_DEADBAND]  = CSR_DAT_W'($urandom_range(0, 300));
         end
      endcase
      drain_results();
      csr_write(REG_OUTER_THRESHOLD,  values[REG_OUTER_THRESHOLD]);
      csr_write(REG_SPARE_LO,         CSR_DAT_W'($urandom_range(0, 16'hFFFF)));
      csr_write(REG_INNER_DEADBAND,   values[REG_INNER_DEADBAND]);
      csr_write(REG_MAX_RELEASE_TIME, values[REG_MAX_RELEASE_TIME]);
      csr_write(REG_FAR_P_GAIN,       values[REG_FAR_P_GAIN]);
      csr_write(REG_FAR_D_GAIN,       values[REG_FAR_D_GAIN]);
      csr_write(REG_NEAR_D_GAIN,      values[REG_NEAR_D_GAIN]);
      csr_write(REG_SPARE_HI,         CSR_DAT_W'($urandom_range(0, 16'hFFFF)));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic signed [ALT_W-1:0] own;
      logic signed [ALT_W-1:0] peer;
      int                      setting;
      int                      n;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed samples under the reset register values. The first transaction sees the
      // zero-filled window right after reset. Then the largest gaps of either sign, one of
      // which overshoots the maximum, the edges of the deadband and of both zones, and a
      // falling gap in the near zone whose negative result must clamp to zero.
      offer_sample('0, '0);
      offer_sample(ALT_MAX, ALT_MIN);
      offer_sample(ALT_MIN, ALT_MAX);
      offer_sample('1, '1);
      offer_sample(24'sd100, 24'sd105);
      offer_sample(24'sd100, 24'sd109);
      offer_sample(24'sd100, 24'sd110);
      offer_sample('0, -24'sd10);
      offer_sample('0, -24'sd9);
      offer_sample('0, 24'sd40);
      offer_sample('0, 24'sd41);
      offer_sample('0, -24'sd39);
      offer_sample('0, -24'sd40);
      offer_sample('0, -24'sd41);
      offer_sample('0, 24'sd30);
      offer_sample('0, 24'sd35);
      offer_sample('0, -24'sd20);
      offer_sample('0, -24'sd35);
      offer_sample(ALT_MIN, '0);
      offer_sample('0, ALT_MIN);

      for (setting = 0; setting < SETTING_COUNT; setting++) begin
         apply_setting(setting);
         // First the sender idles less than the receiver, then the reverse, and in the
         // last two settings neither side idles at all.
         if (setting < 2) begin
            send_idle_pct <= 31;
            recv_idle_pct <= 53;
         end else if (setting < 4) begin
            send_idle_pct <= 53;
            recv_idle_pct <= 31;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         @(posedge clock);
         // With both sides busy, the result side holds off for a long stretch while
         // samples keep coming, so the pipeline fills and stalls the sample channel.
         if (setting == 4) begin
            fork
               begin
                  hold_results <= 1'b1;
                  repeat (HOLD_OFF_CYCLES) @(posedge clock);
                  hold_results <= 1'b0;
               end
            join_none
         end
         for (n = 0; n < RANDOM_PER_SETTING; n++) begin
            // Halfway through one setting the sender stops until every result is back.
            if (setting == 2 && n == RANDOM_PER_SETTING / 2) begin
               drain_results();
            end
            random_sample(own, peer);
            offer_sample(own, peer);
         end
      end

      drain_results();
      repeat (10) @(posedge clock);

      $display("Covered %0d sample transactions over %0d register settings, with corner values,",
               samples_sent, SETTING_COUNT + 1);
      $display("a long result hold-off and a full drain pause; %0d release times checked.",
               checked_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Safety net well beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Timed out with %0d results still pending.", pending_count);
      $display("TEST FAILED");
      $finish;
   end

endmodule
